// File: hw/rtl/fpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and constants of the fixed-point atan2 core
// Holds the sequencer state type, the divider control and status structs and
// the Q15 and Q20 constants of the range reduction and the odd series.
// ----------------------------------------------------------------------------
package fpa_pkg;

    // Range reduction
    localparam logic [15:0] TAN15_Q15   = 16'd8780;   // tan(15 deg) in Q15
    localparam logic [31:0] SQRT3_Q15   = 32'd56756;  // sqrt(3) in Q15
    localparam logic [31:0] ONE_Q30     = 32'h4000_0000;
    localparam logic [15:0] ANGLE_30DEG = 16'd5461;
    localparam logic [2:0]  MAX_STEPS   = 3'd4;

    // Series coefficients, Q20, already scaled to angle units
    localparam logic [31:0] K_ONE   = 32'd166886;
    localparam logic [31:0] K_THIRD = 32'd55629;
    localparam logic [31:0] K_FIFTH = 32'd33377;

    // Angle units, 65536 per turn
    localparam logic [15:0] ANGLE_QUARTER = 16'd16384;
    localparam logic [15:0] ANGLE_HALF    = 16'd32768;

    // Divider geometry: 16 quotient bits, one per cycle
    localparam int          DIV_QBITS = 16;
    localparam logic [3:0]  DIV_LAST  = 4'(DIV_QBITS - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_QUOT,
        S_CHECK,
        S_RED_MUL,
        S_RED_LOAD,
        S_SQ,
        S_Y2,
        S_Y2SQ,
        S_Y4,
        S_B,
        S_C,
        S_SVMUL,
        S_SV,
        S_FIN
    } fpa_state_t;

    typedef struct packed {
        logic        load;
        logic [47:0] dividend;
        logic [31:0] divisor;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// File: hw/rtl/fixed_point_atan2_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_atan2_core: angle of a vector, 65536 units per turn
// Sequencer around one shared divider and one shared multiplier that forms
// the Q15 ratio, folds it to at most tan(15 deg) and evaluates an odd series.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: req_valid/req_ready with coord_y, coord_x (signed 32).
//   Response channel: rsp_valid/rsp_ready with angle (unsigned 16), one
//   item per request, counterclockwise from the positive x axis.
//   req_ready is high only while the sequencer is idle; one item is in
//   work at a time.
//   The time from request to rsp_valid grows with each 30-degree
//   reduction step, taken while the ratio of the smaller to the larger
//   magnitude exceeds tan(15 deg) (one for in-range inputs, four at
//   most). A zero vector skips the divider and answers 0.
//   Each step is bounded by the radix-2 divider, which serves both
//   the ratio and every reduction step; series products go through the
//   shared multiplier.
//   The result sits in an output register, so a new request can be taken
//   while the previous angle waits; a finished item waits in the last
//   sequencer state only while that register is still full.
//   Reset (rst_n low, asynchronous) drops any item in work and any pending
//   response.
// ----------------------------------------------------------------------------
module fixed_point_atan2_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  logic signed [31:0] coord_y,
    input  logic signed [31:0] coord_x,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output logic [15:0]        angle
);
    import fpa_pkg::*;

    fpa_state_t  state_reg, state_next;

    // operand and flag registers
    logic [31:0] ay_reg, ay_next;
    logic [31:0] ax_reg, ax_next;
    logic        inv_reg, inv_next;
    logic        nx_reg, nx_next;
    logic        ny_reg, ny_next;
    logic        zero_reg, zero_next;
    logic [2:0]  iter_reg, iter_next;
    logic [15:0] res_reg, res_next;
    logic [15:0] q_mag_reg, q_mag_next;
    logic        q_neg_reg, q_neg_next;
    logic        num_neg_reg, num_neg_next;

    // series terms
    logic [20:0] y2_reg, y2_next;
    logic [22:0] y4_reg, y4_next;
    logic [17:0] b_reg, b_next;
    logic [31:0] s_reg, s_next;
    logic [15:0] sv_reg, sv_next;

    // output register
    logic        rsp_valid_reg, rsp_valid_next;
    logic [15:0] angle_reg, angle_next;

    // shared units
    div_ctrl_t   div_ctrl;
    div_stat_t   div_stat;
    logic [15:0] div_quot;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_prod;

    // datapath helpers
    logic [31:0] mag_y, mag_x;
    logic [31:0] red_mag;
    logic        red_neg;
    logic [16:0] red_den;
    logic [19:0] c_term;
    logic [15:0] r0, r1, r2;
    logic        out_free;
    logic        req_fire;

    fpa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    fpa_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_prod)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign angle     = angle_reg;

    // Magnitudes; the most negative input comes out as 2^31
    always_comb
    begin
        mag_y = coord_y[31] ? (32'd0 - coord_y) : coord_y;
        mag_x = coord_x[31] ? (32'd0 - coord_x) : coord_x;
    end

    // 30-degree step: numerator q*sqrt3 - 1 as sign and magnitude, denominator
    always_comb
    begin
        red_neg = (mul_prod[31:0] < ONE_Q30);
        red_mag = red_neg ? (ONE_Q30 - mul_prod[31:0]) : (mul_prod[31:0] - ONE_Q30);
        red_den = {1'b0, q_mag_reg} + SQRT3_Q15[16:0];
        c_term  = mul_prod[38:19];
    end

    // Restore the octant and the quadrant, all modulo one turn
    always_comb
    begin
        r0 = q_neg_reg ? (res_reg - sv_reg) : (res_reg + sv_reg);
        r1 = inv_reg ? (ANGLE_QUARTER - r0) : r0;
        if (nx_reg && !ny_reg)
        begin
            r2 = ANGLE_HALF - r1;
        end
        else if (ny_reg && !nx_reg)
        begin
            r2 = 16'd0 - r1;
        end
        else if (nx_reg && ny_reg)
        begin
            r2 = r1 + ANGLE_HALF;
        end
        else
        begin
            r2 = r1;
        end
    end

    // Sequencer: next state, register updates and unit control
    always_comb
    begin
        state_next     = state_reg;
        ay_next        = ay_reg;
        ax_next        = ax_reg;
        inv_next       = inv_reg;
        nx_next        = nx_reg;
        ny_next        = ny_reg;
        zero_next      = zero_reg;
        iter_next      = iter_reg;
        res_next       = res_reg;
        q_mag_next     = q_mag_reg;
        q_neg_next     = q_neg_reg;
        num_neg_next   = num_neg_reg;
        y2_next        = y2_reg;
        y4_next        = y4_reg;
        b_next         = b_reg;
        s_next         = s_reg;
        sv_next        = sv_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        angle_next     = angle_reg;
        div_ctrl       = '0;
        mul_a          = '0;
        mul_b          = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    nx_next = coord_x[31];
                    ny_next = coord_y[31];
                    // smaller magnitude becomes the numerator
                    if (mag_y > mag_x)
                    begin
                        ay_next  = mag_x;
                        ax_next  = mag_y;
                        inv_next = 1'b1;
                    end
                    else
                    begin
                        ay_next  = mag_y;
                        ax_next  = mag_x;
                        inv_next = 1'b0;
                    end
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                res_next     = '0;
                iter_next    = '0;
                num_neg_next = 1'b0;
                q_neg_next   = 1'b0;
                if (ax_reg == 32'd0)
                begin
                    zero_next  = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    // ratio in Q15: (ay << 15) / ax
                    zero_next         = 1'b0;
                    div_ctrl.load     = 1'b1;
                    div_ctrl.dividend = {1'b0, ay_reg, 15'd0};
                    div_ctrl.divisor  = ax_reg;
                    state_next        = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_QUOT;
                end
            end
            S_QUOT:
            begin
                q_mag_next = div_quot;
                q_neg_next = num_neg_reg && (div_quot != 16'd0);
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (!q_neg_reg && (q_mag_reg > TAN15_Q15) && (iter_reg < MAX_STEPS))
                begin
                    res_next   = res_reg + ANGLE_30DEG;
                    iter_next  = iter_reg + 3'd1;
                    state_next = S_RED_MUL;
                end
                else
                begin
                    state_next = S_SQ;
                end
            end
            S_RED_MUL:
            begin
                mul_a      = {16'd0, q_mag_reg};
                mul_b      = SQRT3_Q15;
                state_next = S_RED_LOAD;
            end
            S_RED_LOAD:
            begin
                num_neg_next      = red_neg;
                div_ctrl.load     = 1'b1;
                div_ctrl.dividend = {17'd0, red_mag[30:0]};
                div_ctrl.divisor  = {15'd0, red_den};
                state_next        = S_DIV;
            end
            S_SQ:
            begin
                mul_a      = {16'd0, q_mag_reg};
                mul_b      = {16'd0, q_mag_reg};
                state_next = S_Y2;
            end
            S_Y2:
            begin
                y2_next    = mul_prod[31:11];
                state_next = S_Y2SQ;
            end
            S_Y2SQ:
            begin
                mul_a      = {11'd0, y2_reg};
                mul_b      = {11'd0, y2_reg};
                state_next = S_Y4;
            end
            S_Y4:
            begin
                y4_next    = mul_prod[41:19];
                mul_a      = {11'd0, y2_reg};
                mul_b      = K_THIRD;
                state_next = S_B;
            end
            S_B:
            begin
                b_next     = mul_prod[36:19];
                mul_a      = {9'd0, y4_reg};
                mul_b      = K_FIFTH;
                state_next = S_C;
            end
            S_C:
            begin
                s_next     = K_ONE - {14'd0, b_reg} + {12'd0, c_term};
                state_next = S_SVMUL;
            end
            S_SVMUL:
            begin
                mul_a      = {16'd0, q_mag_reg};
                mul_b      = s_reg;
                state_next = S_SV;
            end
            S_SV:
            begin
                sv_next    = mul_prod[34:19];
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // hold the item until the output register is free
                if (out_free)
                begin
                    angle_next     = zero_reg ? 16'd0 : r2;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            iter_reg      <= '0;
            q_neg_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            iter_reg      <= iter_next;
            q_neg_reg     <= q_neg_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        ay_reg      <= ay_next;
        ax_reg      <= ax_next;
        inv_reg     <= inv_next;
        nx_reg      <= nx_next;
        ny_reg      <= ny_next;
        zero_reg    <= zero_next;
        res_reg     <= res_next;
        q_mag_reg   <= q_mag_next;
        num_neg_reg <= num_neg_next;
        y2_reg      <= y2_next;
        y4_reg      <= y4_next;
        b_reg       <= b_next;
        s_reg       <= s_next;
        sv_reg      <= sv_next;
        angle_reg   <= angle_next;
    end

    // Checks
    a_div_busy_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> div_stat.busy)
        else $error("sequencer waits on an idle divider");

    a_div_done_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide state");

    a_no_neg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        q_neg_reg |-> q_mag_reg != 16'd0)
        else $error("negative flag set on a zero ratio");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CHECK |-> iter_reg <= MAX_STEPS)
        else $error("too many reduction steps");

    a_fin_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) && out_free |=> rsp_valid_reg && (state_reg == S_IDLE))
        else $error("finished item not moved to the output register");

endmodule

// File: hw/rtl/fpa_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_div: radix-2 restoring divider, one quotient bit per cycle
// Divides a 48-bit dividend by a 32-bit divisor where the quotient is known
// to fit in 16 bits. Shared by the ratio and the 30-degree reduction steps.
// ----------------------------------------------------------------------------
module fpa_div (
    input  logic              clk,
    input  logic              rst_n,
    input  fpa_pkg::div_ctrl_t ctrl,
    output fpa_pkg::div_stat_t stat,
    output logic [15:0]       quotient
);
    import fpa_pkg::*;

    logic        busy_reg, busy_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [15:0] lo_reg, lo_next;
    logic [31:0] den_reg, den_next;

    logic [32:0] shifted;
    logic [32:0] diff;
    logic        ge;

    // One trial subtraction per cycle
    always_comb
    begin
        shifted = {rem_reg, lo_reg[15]};
        diff    = shifted - {1'b0, den_reg};
        ge      = (shifted >= {1'b0, den_reg});
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        den_next  = den_reg;
        if (ctrl.load)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = ctrl.dividend[47:16];
            lo_next   = ctrl.dividend[15:0];
            den_next  = ctrl.divisor;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so 32 bits hold it
            rem_next = ge ? diff[31:0] : shifted[31:0];
            lo_next  = {lo_reg[14:0], ge};
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == DIV_LAST)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        den_reg <= den_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && (cnt_reg == DIV_LAST);
    assign quotient  = lo_reg;

endmodule

// File: hw/rtl/fpa_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_mul: shared 32x32 unsigned multiplier with registered product
// Every product of the core goes through this unit, one per cycle.
// ----------------------------------------------------------------------------
module fpa_mul (
    input  logic        clk,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic [63:0] prod
);
    import fpa_pkg::*;

    logic [63:0] prod_reg, prod_next;

    // full-width product of the operands selected this cycle
    always_comb
    begin
        prod_next = {32'd0, op_a} * {32'd0, op_b};
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the fixed-point atan2 core
// A queue of vectors feeds a request driver; a response monitor compares each
// angle with a bit-exact software predictor of the Q15 reduction and series.
// Both channels idle at random; one long response stall backs the core up.
// ----------------------------------------------------------------------------
module tb_top;

    // Run control
    localparam int LIMIT_CYCLES = 800000;
    localparam int DRAIN_CYCLES = 150;
    localparam int HOLD_AT      = 120;
    localparam int LONG_HOLD    = 400;

    // Predictor constants, Q15 reduction and Q20 series
    localparam longint      TAN15   = 8780;
    localparam longint      SQRT3   = 56756;
    localparam longint      ONE_Q30 = 64'd1073741824;
    localparam int          STEPS   = 4;
    localparam logic [31:0] ANG30   = 32'd5461;
    localparam logic [31:0] K_ONE   = 32'd166886;
    localparam logic [31:0] K_THIRD = 32'd55629;
    localparam logic [31:0] K_FIFTH = 32'd33377;
    localparam logic [31:0] QUARTER = 32'd16384;
    localparam logic [31:0] HALF    = 32'd32768;
    localparam logic [31:0] FULL    = 32'd65536;

    localparam logic [31:0] MAXP = 32'h7FFF_FFFF;
    localparam logic [31:0] MAXN = 32'h8000_0001;

    typedef struct packed {
        logic [31:0] y;
        logic [31:0] x;
        logic [7:0]  gap;
        logic        drain;
    } vec_item_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_ready;
    logic signed [31:0] coord_y   = '0;
    logic signed [31:0] coord_x   = '0;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    logic [15:0]        angle;

    vec_item_t   vec_q[$];
    logic [15:0] angle_exp_q[$];

    vec_item_t cur;
    bit        have_cur  = 1'b0;
    int        gap_left  = 0;
    logic      req_fire  = 1'b0;
    int        req_count = 0;
    int        fail_cnt  = 0;
    int        cycle_cnt = 0;
    int        total_items;
    int        stall_cnt = 0;
    int        hold_cnt  = 0;
    bit        hold_done = 1'b0;

    fixed_point_atan2_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .coord_y   (coord_y),
        .coord_x   (coord_x),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .angle     (angle)
    );

    always #1 clk = ~clk;

    // (a * b) >> sh on 64 bits, kept to 32 bits
    function automatic logic [31:0] mul_shr(input logic [31:0] a, input logic [31:0] b,
                                            input int sh);
        logic [63:0] p;
        begin
            p = {32'd0, a} * {32'd0, b};
            p = p >> sh;
            return p[31:0];
        end
    endfunction

    // Expected angle of (cx, cy), 65536 units per turn
    function automatic logic [15:0] atan2_angle(input logic [31:0] cy, input logic [31:0] cx);
        logic [31:0]     ay, ax, tmp, res, t, y2, y4, b, c, poly, sv;
        logic            ny, nx, inv, nq;
        longint          q, num, den;
        longint unsigned ratio;
        int              i;
        begin
            ny  = cy[31];
            nx  = cx[31];
            ay  = ny ? 32'd0 - cy : cy;
            ax  = nx ? 32'd0 - cx : cx;
            inv = 1'b0;
            if (ay > ax) begin
                tmp = ax;
                ax  = ay;
                ay  = tmp;
                inv = 1'b1;
            end
            if (ax == 32'd0)
                return 16'd0;

            ratio = ({32'd0, ay} << 15) / {32'd0, ax};
            q     = longint'(ratio);
            res   = 32'd0;

            // fold by 30 degrees, up to STEPS times, until the ratio is at most tan(15 deg)
            for (i = 0; i < STEPS && q > TAN15; i++) begin
                num = q * SQRT3 - ONE_Q30;
                den = q + SQRT3;
                res = res + ANG30;
                q   = num / den;
            end

            nq = (q < 0);
            if (nq)
                q = -q;

            // odd series on the reduced ratio
            t    = q[31:0];
            y2   = mul_shr(t, t, 11);
            y4   = mul_shr(y2, y2, 19);
            b    = mul_shr(y2, K_THIRD, 19);
            c    = mul_shr(y4, K_FIFTH, 19);
            poly = K_ONE - b + c;
            sv   = mul_shr(t, poly, 19);
            res  = nq ? res - sv : res + sv;

            // octant, then quadrant
            if (inv)
                res = QUARTER - res;
            if (nx && !ny)
                res = HALF - res;
            else if (ny && !nx)
                res = FULL - res;
            else if (nx && ny)
                res = res + HALF;
            return res[15:0];
        end
    endfunction

    // Idle length: mostly none, some short, a few long
    function automatic int pick_idle();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                return 0;
            if (r < 90)
                return $urandom_range(1, 3);
            if (r < 97)
                return $urandom_range(4, 12);
            return $urandom_range(20, 80);
        end
    endfunction

    function automatic logic [31:0] apply_sign(input logic [31:0] mag);
        return ($urandom_range(0, 1) == 1) ? 32'd0 - mag : mag;
    endfunction

    // Component of assorted scales, never -2^31
    function automatic logic [31:0] rand_coord();
        logic [31:0] mag;
        begin
            case ($urandom_range(0, 3))
                0:       mag = $urandom & MAXP;
                1:       mag = $urandom_range(0, 2000);
                2:       mag = ($urandom & MAXP) >> $urandom_range(0, 30);
                default: mag = ($urandom_range(0, 1) == 1) ? MAXP : 32'd0;
            endcase
            return apply_sign(mag);
        end
    endfunction

    task automatic add_vec(input logic [31:0] y, input logic [31:0] x, input int gap,
                           input bit drain);
        vec_item_t it;
        begin
            it.y     = y;
            it.x     = x;
            it.gap   = 8'(gap);
            it.drain = drain;
            vec_q.push_back(it);
        end
    endtask

    // Random vector with a chosen ratio, often near the fold points
    task automatic add_ratio_vec(input int gap, input bit drain);
        logic [31:0] big, sm;
        logic [63:0] p;
        int          k;
        begin
            big = $urandom_range(1, MAXP) >> $urandom_range(0, 20);
            if (big == 32'd0)
                big = 32'd1;
            case ($urandom_range(0, 3))
                0:       k = $urandom_range(8730, 8830);
                1:       k = $urandom_range(18868, 18968);
                2:       k = $urandom_range(32700, 32768);
                default: k = $urandom_range(0, 32768);
            endcase
            p  = ({32'd0, big} * 64'(k)) >> 15;
            sm = p[31:0];
            if ($urandom_range(0, 1) == 1)
                add_vec(apply_sign(big), apply_sign(sm), gap, drain);
            else
                add_vec(apply_sign(sm), apply_sign(big), gap, drain);
        end
    endtask

    // Request driver
    always @(negedge clk) begin
        if (!rst_n) begin
            req_valid <= 1'b0;
            coord_y   <= '0;
            coord_x   <= '0;
        end
        else if (req_valid && !req_fire) begin
            // hold the offered item
        end
        else begin
            if (!have_cur && vec_q.size() != 0) begin
                cur      = vec_q.pop_front();
                gap_left = cur.gap;
                have_cur = 1'b1;
            end
            if (!have_cur)
                req_valid <= 1'b0;
            else if (gap_left > 0) begin
                req_valid <= 1'b0;
                gap_left = gap_left - 1;
            end
            else if (cur.drain && angle_exp_q.size() != 0)
                req_valid <= 1'b0;
            else begin
                req_valid <= 1'b1;
                coord_y   <= cur.y;
                coord_x   <= cur.x;
                have_cur = 1'b0;
            end
        end
    end

    // Response receiver, with one long hold once HOLD_AT requests are accepted
    always @(negedge clk) begin
        if (!rst_n) begin
            rsp_ready <= 1'b0;
            stall_cnt = 0;
            hold_cnt  = 0;
        end
        else if (hold_cnt > 0) begin
            rsp_ready <= 1'b0;
            hold_cnt = hold_cnt - 1;
        end
        else if (!hold_done && req_count >= HOLD_AT) begin
            rsp_ready <= 1'b0;
            hold_done = 1'b1;
            hold_cnt  = LONG_HOLD;
        end
        else if (stall_cnt > 0) begin
            rsp_ready <= 1'b0;
            stall_cnt = stall_cnt - 1;
        end
        else begin
            rsp_ready <= 1'b1;
            // every fourth window of the cycle count runs without stalls
            if ((cycle_cnt / 3000) % 4 != 1)
                stall_cnt = pick_idle();
        end
    end

    // Monitor: check responses, then predict accepted requests
    always @(posedge clk) begin
        logic [15:0] exp_angle;
        req_fire <= rst_n && req_valid && req_ready;
        if (rst_n) begin
            if (rsp_valid && rsp_ready) begin
                if (angle_exp_q.size() == 0) begin
                    $error("angle: no item expected, actual %0d", angle);
                    fail_cnt++;
                end
                else begin
                    exp_angle = angle_exp_q.pop_front();
                    if (angle !== exp_angle) begin
                        $error("angle mismatch: expected %0d, actual %0d", exp_angle, angle);
                        fail_cnt++;
                    end
                end
            end
            if (req_valid && req_ready) begin
                angle_exp_q.push_back(atan2_angle(coord_y, coord_x));
                req_count++;
            end
        end
    end

    // Cycle limit
    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int n;
        int gap;

        // directed: axes, extremes, fold boundaries, negative reduced ratio,
        // full-turn wrap, all quadrants with and without the octant swap
        add_vec(32'd0, 32'd0, 0, 1'b0);
        add_vec(32'd0, 32'd1, 0, 1'b0);
        add_vec(32'd1, 32'd0, 0, 1'b0);
        add_vec(32'd0, 32'hFFFF_FFFF, 2, 1'b0);
        add_vec(32'hFFFF_FFFF, 32'd0, 0, 1'b0);
        add_vec(MAXP, MAXP, 0, 1'b0);
        add_vec(MAXN, MAXN, 0, 1'b0);
        add_vec(MAXP, MAXN, 0, 1'b0);
        add_vec(MAXN, MAXP, 5, 1'b0);
        add_vec(32'd0, MAXP, 0, 1'b0);
        add_vec(MAXP, 32'd0, 0, 1'b0);
        add_vec(32'd0, MAXN, 0, 1'b0);
        add_vec(MAXN, 32'd0, 0, 1'b0);
        add_vec(32'd1, MAXP, 0, 1'b0);
        add_vec(MAXP, 32'd1, 0, 1'b0);
        add_vec(32'd8780, 32'd32768, 0, 1'b0);
        add_vec(32'd8781, 32'd32768, 0, 1'b0);
        add_vec(32'd10000, 32'd32768, 0, 1'b0);
        add_vec(32'd32767, 32'd32768, 0, 1'b0);
        add_vec(32'hFFFF_FFFF, MAXP, 0, 1'b0);
        add_vec(32'hFFFF_FFFF, 32'd1000000, 0, 1'b0);
        add_vec(32'hFFFF_FFFD, 32'd7, 0, 1'b0);
        add_vec(32'd7, 32'hFFFF_FFFD, 0, 1'b0);
        add_vec(32'hFFFF_FFF9, 32'hFFFF_FFFD, 0, 1'b0);

        // random: half chosen ratios, half free components
        for (n = 0; n < 530; n++) begin
            gap = (n >= 150 && n < 230) ? 0 : pick_idle();
            if ($urandom_range(0, 1) == 1)
                add_ratio_vec(gap, (n == 0 || n == 300));
            else
                add_vec(rand_coord(), rand_coord(), gap, (n == 0 || n == 300));
        end
        total_items = vec_q.size();

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        while (req_count < total_items || angle_exp_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/fpa_pkg.sv
hw/rtl/fpa_div.sv
hw/rtl/fpa_mul.sv
hw/rtl/fixed_point_atan2_core.sv
verif/tb_top.sv
